>>> rtl/core/atss_pkg.sv
`default_nettype none
package atss_pkg;

  localparam int FRAC_BITS = 8;
  localparam int QUIET_ITEMS = 10;
  localparam int SUM_WIDTH = 24;

  localparam int ONE = 1 << FRAC_BITS;
  localparam int QW = 4;
  localparam int DIV_W = 8 + FRAC_BITS;
  localparam int DIV_CW = $clog2(DIV_W);

  // CORDIC datapath widths and the shared multiplier.
  localparam int CW = 36;
  localparam int AW = 21;
  localparam int MW = 22;
  localparam int PW = 2 * MW;

  localparam logic signed [AW-1:0] CORDIC_PI = 21'sd205887;
  localparam logic [32:0] SHAKE_LIM = 33'((longint'(484) << (2 * FRAC_BITS)) / 100);

  typedef enum logic [4:0] {
    S_IDLE, S_CSET, S_CDIV, S_CFIN, S_CMP, S_SQX, S_SQY, S_SQZ, S_SQE,
    S_RCOR, S_RMUL, S_RABS, S_RREC, S_RFIN, S_SQRT, S_PSET, S_PCOR,
    S_PMUL, S_PFIN, S_FLAG, S_SWG, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    R_ZERO_X = 3'd0, R_ZERO_Y = 3'd1, R_ZERO_Z = 3'd2,
    R_ONE_G_X = 3'd3, R_ONE_G_Y = 3'd4, R_ONE_G_Z = 3'd5
  } reg_idx_t;

  // Rounded atan(2^-i) in Q16 radians.
  function automatic logic [16:0] atan_entry(input logic [3:0] i);
    logic [16:0] r;
    case (i)
      4'd0: r = 17'd51472;
      4'd1: r = 17'd30386;
      4'd2: r = 17'd16055;
      4'd3: r = 17'd8150;
      4'd4: r = 17'd4091;
      4'd5: r = 17'd2047;
      4'd6: r = 17'd1024;
      4'd7: r = 17'd512;
      4'd8: r = 17'd256;
      4'd9: r = 17'd128;
      4'd10: r = 17'd64;
      4'd11: r = 17'd32;
      4'd12: r = 17'd16;
      4'd13: r = 17'd8;
      4'd14: r = 17'd4;
      default: r = 17'd2;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/atss_ifs.sv
`default_nettype none
interface atss_sample_if;
  logic valid;
  logic ready;
  logic [7:0] raw_x;
  logic [7:0] raw_y;
  logic [7:0] raw_z;
  modport source(output valid, output raw_x, output raw_y, output raw_z, input ready);
  modport sink(input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

interface atss_result_if;
  logic valid;
  logic ready;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic tilt_front;
  logic tilt_back;
  logic tilt_left;
  logic tilt_right;
  logic shake;
  logic [2:0] swing;
  logic gesture_changed;
  modport source(output valid, output roll_angle, output pitch_angle, output tilt_front,
                 output tilt_back, output tilt_left, output tilt_right, output shake,
                 output swing, output gesture_changed, input ready);
  modport sink(input valid, input roll_angle, input pitch_angle, input tilt_front,
               input tilt_back, input tilt_left, input tilt_right, input shake,
               input swing, input gesture_changed, output ready);
endinterface
`default_nettype wire

>>> rtl/core/accel_tilt_shake_swing_classifier_top.sv
// Accelerometer tilt, shake and swing classifier.
// The samples channel takes one raw 3-axis byte triple per beat; the results
// channel gives at most one beat per sample: roll and pitch angles, four tilt
// flags, a shake flag, a one-beat swing code and a gesture-changed flag.
// A sample whose calibrated axes equal the previous sample gives no beat.
// The calibration registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle, which the block
// itself does not enforce; an index beyond the list is ignored.
// samples.ready is high only while the sequencer is idle. A sample runs
// through three restoring divisions one quotient bit a cycle, two 16-step
// CORDIC passes and a 30-step square root on one shared 22x22 multiplier.
// With calibrated z equal to zero the angles are kept and the CORDIC and
// square-root steps skipped; an unchanged sample drops after the divisions.
// The result sits in an output register; a stalled receiver does not stop
// the next sample, but a finished result waits until the register frees.
// Synchronous reset restores the calibration defaults and clears history.
`default_nettype none
module accel_tilt_shake_swing_classifier_top (
  input  logic clk,
  input  logic rst,
  atss_sample_if.sink samples,
  atss_result_if.source results,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int CW = atss_pkg::CW;
  localparam int AW = atss_pkg::AW;
  localparam int MW = atss_pkg::MW;
  localparam int PW = atss_pkg::PW;
  localparam int DW = atss_pkg::DIV_W;
  localparam int DCW = atss_pkg::DIV_CW;
  localparam int SW = atss_pkg::SUM_WIDTH;
  localparam int SW1 = SW + 1;
  localparam int ABW = SW + 2;
  localparam int ONE = atss_pkg::ONE;
  localparam int QW = atss_pkg::QW;
  localparam logic [QW-1:0] QLOAD = QW'(atss_pkg::QUIET_ITEMS);
  localparam logic signed [SW1-1:0] PMAX = SW1'((longint'(1) << (SW - 1)) - 1);
  localparam logic signed [SW1-1:0] NMIN = SW1'(-(longint'(1) << (SW - 1)));
  localparam logic signed [ABW-1:0] A5 = ABW'(5 * ONE);
  localparam logic signed [ABW-1:0] A10 = ABW'(10 * ONE);
  localparam logic signed [ABW-1:0] A20 = ABW'(20 * ONE);
  localparam logic signed [ABW-1:0] A40 = ABW'(40 * ONE);
  localparam logic signed [ABW-1:0] A60 = ABW'(60 * ONE);
  localparam logic signed [ABW-1:0] A80 = ABW'(80 * ONE);
  localparam logic signed [ABW-1:0] N1 = ABW'(-1 * ONE);
  localparam logic signed [ABW-1:0] N2 = ABW'(-2 * ONE);
  localparam logic signed [ABW-1:0] N3 = ABW'(-3 * ONE);
  localparam logic signed [ABW-1:0] N4 = ABW'(-4 * ONE);
  localparam logic [16:0] BIG_LIM = 17'(2 * ONE);

  atss_pkg::state_t state, state_next;

  logic [7:0] zero_g [3];
  logic [7:0] one_g [3];
  logic [7:0] raw [3];

  // Calibration divider.
  logic [1:0] axis;
  logic [DCW-1:0] dcnt;
  logic [DW-1:0] div_n, div_q;
  logic [7:0] div_d, div_rem;
  logic div_neg, den_zero;
  logic signed [8:0] num_r;
  logic signed [8:0] num_w, den_w;
  logic [8:0] rem2;

  logic signed [15:0] v [3];
  logic signed [15:0] pv [3];
  logic have_prev;

  // Shared multiplier.
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  logic [PW-1:0] nabs;

  logic [31:0] sq_xz;
  logic [30:0] sq_y;
  logic [32:0] mag2;

  // CORDIC.
  logic signed [CW-1:0] ca, cb, cda, cdb;
  logic signed [AW-1:0] cang;
  logic [3:0] it;
  logic rneg;
  logic [18:0] rt;
  logic [16:0] rq, rc;
  logic [15:0] pq, pc;

  // Square root.
  logic [59:0] srem, sres, sbit, ssum;
  logic [4:0] sk;

  logic signed [15:0] roll_r;
  logic signed [14:0] pitch_r;
  logic [8:0] gbits;
  logic [4:0] nbits;
  logic [4:0] nbits_w;
  logic chg;
  logic [QW-1:0] qc;
  logic signed [SW-1:0] psum [3];
  logic signed [SW-1:0] nsum [3];
  logic [2:0] lpos, seen;
  logic signed [SW1-1:0] padd [3];
  logic signed [SW1-1:0] nadd [3];
  logic [16:0] mabs [3];
  logic [2:0] bigv;
  logic signed [ABW-1:0] val [3];
  logic signed [ABW-1:0] ab [3];
  logic signed [ABW-1:0] ab1;
  logic [2:0] swing_w;
  logic fire;

  logic ov;
  logic signed [15:0] o_roll;
  logic signed [14:0] o_pitch;
  logic [7:0] o_bits;
  logic o_chg;

  assign samples.ready = (state == atss_pkg::S_IDLE);
  assign results.valid = ov;
  assign results.roll_angle = o_roll;
  assign results.pitch_angle = o_pitch;
  assign results.tilt_front = o_bits[0];
  assign results.tilt_back = o_bits[1];
  assign results.tilt_left = o_bits[2];
  assign results.tilt_right = o_bits[3];
  assign results.shake = o_bits[4];
  assign results.swing = o_bits[7:5];
  assign results.gesture_changed = o_chg;

  always_comb begin
    num_w = $signed({1'b0, raw[axis]}) - $signed({1'b0, zero_g[axis]});
    den_w = $signed({1'b0, one_g[axis]}) - $signed({1'b0, zero_g[axis]});
    rem2 = {div_rem, div_n[DW-1]};
    nabs = mul_p[PW-1] ? PW'(-mul_p) : PW'(mul_p);
    cda = cb >>> it;
    cdb = ca >>> it;
    sbit = 60'(1) << {sk, 1'b0};
    ssum = sres + sbit;
    rq = mul_p[39:23];
    rc = (rq > 17'd23040) ? 17'd23040 : rq;
    pq = 16'((nabs + PW'(256)) >> 9);
    pc = (pq > 16'd11520) ? 16'd11520 : pq;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      atss_pkg::S_SQX: begin mul_a = MW'(v[0]); mul_b = MW'(v[0]); end
      atss_pkg::S_SQY: begin mul_a = MW'(v[1]); mul_b = MW'(v[1]); end
      atss_pkg::S_SQZ: begin mul_a = MW'(v[2]); mul_b = MW'(v[2]); end
      atss_pkg::S_RMUL: begin mul_a = MW'(cang); mul_b = MW'(75264); end
      atss_pkg::S_RREC: begin mul_a = MW'({1'b0, rt}); mul_b = MW'(838861); end
      atss_pkg::S_PMUL: begin mul_a = MW'(cang); mul_b = MW'(59); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Tilt hysteresis, shake and per-axis accumulation terms.
  always_comb begin
    nbits_w[0] = (pitch_r < -15'sd3840) || (gbits[0] && (pitch_r < -15'sd2560));
    nbits_w[1] = (pitch_r > 15'sd3840) || (gbits[1] && (pitch_r > 15'sd2560));
    nbits_w[2] = (roll_r < -16'sd5760) || (gbits[2] && (roll_r < -16'sd4480));
    nbits_w[3] = (roll_r > 16'sd5760) || (gbits[3] && (roll_r > 16'sd4480));
    nbits_w[4] = mag2 > atss_pkg::SHAKE_LIM;
    for (int i = 0; i < 3; i++) begin
      mabs[i] = v[i][15] ? 17'(-$signed({v[i][15], v[i]})) : 17'({1'b0, v[i]});
      bigv[i] = mabs[i] > BIG_LIM;
      padd[i] = SW1'(psum[i]) + SW1'(v[i]);
      nadd[i] = SW1'(nsum[i]) + SW1'(v[i]);
    end
  end

  // Swing decision over the accumulated sums.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      val[i] = seen[i] ? (lpos[i] ? ABW'(psum[i]) : ABW'(nsum[i])) : '0;
      ab[i] = (val[i] < 0) ? -val[i] : val[i];
    end
    ab1 = ab[1];
    if (ab[0] > A20) ab1 = ab1 - A80;
    else if (ab[0] > A10) ab1 = ab1 - A40;
    else if (ab[0] > A5) ab1 = ab1 - A20;
    if (val[1] < N4) ab1 = ab1 + A60;
    else if (val[1] < N3) ab1 = ab1 + A40;
    else if (val[1] < N2) ab1 = ab1 + A20;
    else if (val[1] < N1) ab1 = ab1 + A10;
    fire = (qc == '0) && (seen != 3'b000);
    swing_w = 3'd0;
    if (fire) begin
      if (ab[0] > ab1 && ab[0] > ab[2]) swing_w = (val[0] > 0) ? 3'd1 : 3'd2;
      else if (ab1 > ab[0] && ab1 > ab[2]) swing_w = (val[1] > 0) ? 3'd3 : 3'd4;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      atss_pkg::S_IDLE: if (samples.valid) state_next = atss_pkg::S_CSET;
      atss_pkg::S_CSET: state_next = atss_pkg::S_CDIV;
      atss_pkg::S_CDIV: if (dcnt == '0) state_next = atss_pkg::S_CFIN;
      atss_pkg::S_CFIN: state_next = (axis == 2'd2) ? atss_pkg::S_CMP : atss_pkg::S_CSET;
      atss_pkg::S_CMP: begin
        if (have_prev && v[0] == pv[0] && v[1] == pv[1] && v[2] == pv[2])
          state_next = atss_pkg::S_IDLE;
        else
          state_next = atss_pkg::S_SQX;
      end
      atss_pkg::S_SQX: state_next = atss_pkg::S_SQY;
      atss_pkg::S_SQY: state_next = atss_pkg::S_SQZ;
      atss_pkg::S_SQZ: state_next = atss_pkg::S_SQE;
      atss_pkg::S_SQE: state_next = (v[2] == 0) ? atss_pkg::S_FLAG : atss_pkg::S_RCOR;
      atss_pkg::S_RCOR: if (it == 4'd15) state_next = atss_pkg::S_RMUL;
      atss_pkg::S_RMUL: state_next = atss_pkg::S_RABS;
      atss_pkg::S_RABS: state_next = atss_pkg::S_RREC;
      atss_pkg::S_RREC: state_next = atss_pkg::S_RFIN;
      atss_pkg::S_RFIN: state_next = atss_pkg::S_SQRT;
      atss_pkg::S_SQRT: if (sk == 5'd0) state_next = atss_pkg::S_PSET;
      atss_pkg::S_PSET: state_next = atss_pkg::S_PCOR;
      atss_pkg::S_PCOR: if (it == 4'd15) state_next = atss_pkg::S_PMUL;
      atss_pkg::S_PMUL: state_next = atss_pkg::S_PFIN;
      atss_pkg::S_PFIN: state_next = atss_pkg::S_FLAG;
      atss_pkg::S_FLAG: state_next = atss_pkg::S_SWG;
      atss_pkg::S_SWG: state_next = atss_pkg::S_OUT;
      atss_pkg::S_OUT: if (!ov || results.ready) state_next = atss_pkg::S_IDLE;
      default: state_next = atss_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= atss_pkg::S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // Payload datapath.
  always_ff @(posedge clk) begin
    case (state)
      atss_pkg::S_IDLE: begin
        raw[0] <= samples.raw_x;
        raw[1] <= samples.raw_y;
        raw[2] <= samples.raw_z;
        axis <= 2'd0;
      end
      atss_pkg::S_CSET: begin
        num_r <= num_w;
        div_n <= DW'(num_w[8] ? 9'(-num_w) : 9'(num_w)) << atss_pkg::FRAC_BITS;
        div_d <= 8'(den_w[8] ? 9'(-den_w) : 9'(den_w));
        div_neg <= num_w[8] ^ den_w[8];
        den_zero <= (den_w == 0);
        div_rem <= '0;
        div_q <= '0;
        dcnt <= DCW'(DW - 1);
      end
      atss_pkg::S_CDIV: begin
        if (rem2 >= {1'b0, div_d}) begin
          div_rem <= 8'(rem2 - {1'b0, div_d});
          div_q <= {div_q[DW-2:0], 1'b1};
        end else begin
          div_rem <= rem2[7:0];
          div_q <= {div_q[DW-2:0], 1'b0};
        end
        div_n <= div_n << 1;
        dcnt <= dcnt - 1'b1;
      end
      atss_pkg::S_CFIN: begin
        if (den_zero)
          v[axis] <= (num_r > 0) ? 16'sd32767 : ((num_r < 0) ? -16'sd32768 : 16'sd0);
        else if (!div_neg)
          v[axis] <= (div_q > 32767) ? 16'sd32767 : $signed(16'(div_q));
        else
          v[axis] <= (div_q > 32768) ? -16'sd32768 : $signed(16'(DW'(0) - div_q));
        axis <= axis + 1'b1;
      end
      atss_pkg::S_SQY: sq_xz <= mul_p[31:0];
      atss_pkg::S_SQZ: sq_y <= mul_p[30:0];
      atss_pkg::S_SQE: begin
        sq_xz <= sq_xz + mul_p[31:0];
        mag2 <= {1'b0, sq_xz} + mul_p[32:0] + 33'(sq_y);
        it <= 4'd0;
        if (v[2] < 0) begin
          ca <= -(CW'(v[2]) <<< 14);
          cb <= -(CW'(v[0]) <<< 14);
          cang <= (v[0] > 0) ? atss_pkg::CORDIC_PI : -atss_pkg::CORDIC_PI;
        end else begin
          ca <= CW'(v[2]) <<< 14;
          cb <= CW'(v[0]) <<< 14;
          cang <= '0;
        end
      end
      atss_pkg::S_RCOR, atss_pkg::S_PCOR: begin
        if (!cb[CW-1]) begin
          ca <= ca + cda;
          cb <= cb - cdb;
          cang <= cang + AW'(atss_pkg::atan_entry(it));
        end else begin
          ca <= ca - cda;
          cb <= cb + cdb;
          cang <= cang - AW'(atss_pkg::atan_entry(it));
        end
        it <= it + 1'b1;
      end
      atss_pkg::S_RABS: begin
        rneg <= mul_p[PW-1];
        rt <= 19'((nabs + PW'(327680)) >> 16);
      end
      atss_pkg::S_RFIN: begin
        srem <= {sq_xz, 28'd0};
        sres <= '0;
        sk <= 5'd29;
      end
      atss_pkg::S_SQRT: begin
        if (srem >= ssum) begin
          srem <= srem - ssum;
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sk <= sk - 1'b1;
      end
      atss_pkg::S_PSET: begin
        ca <= CW'(sres);
        cb <= CW'(v[1]) <<< 14;
        cang <= '0;
        it <= 4'd0;
      end
      atss_pkg::S_FLAG: nbits <= nbits_w;
      atss_pkg::S_SWG: chg <= ({1'b0, swing_w, nbits} != gbits);
      default: ;
    endcase
  end

  // History, gesture and configuration state.
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_g[0] <= 8'd128; zero_g[1] <= 8'd128; zero_g[2] <= 8'd128;
      one_g[0] <= 8'd154; one_g[1] <= 8'd154; one_g[2] <= 8'd154;
      have_prev <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pv[i] <= '0;
        psum[i] <= '0;
        nsum[i] <= '0;
      end
      lpos <= '0;
      seen <= '0;
      qc <= '0;
      gbits <= '0;
      roll_r <= '0;
      pitch_r <= '0;
      ov <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          atss_pkg::R_ZERO_X: zero_g[0] <= cfg_data;
          atss_pkg::R_ZERO_Y: zero_g[1] <= cfg_data;
          atss_pkg::R_ZERO_Z: zero_g[2] <= cfg_data;
          atss_pkg::R_ONE_G_X: one_g[0] <= cfg_data;
          atss_pkg::R_ONE_G_Y: one_g[1] <= cfg_data;
          atss_pkg::R_ONE_G_Z: one_g[2] <= cfg_data;
          default: ;
        endcase
      end
      if (state == atss_pkg::S_OUT && (!ov || results.ready)) ov <= 1'b1;
      else if (ov && results.ready) ov <= 1'b0;
      case (state)
        atss_pkg::S_CMP: begin
          have_prev <= 1'b1;
          for (int i = 0; i < 3; i++) pv[i] <= v[i];
        end
        atss_pkg::S_RFIN: roll_r <= rneg ? -$signed({1'b0, rc[14:0]}) : $signed({1'b0, rc[14:0]});
        atss_pkg::S_PFIN:
          pitch_r <= mul_p[PW-1] ? $signed(pc[14:0]) : -$signed(pc[14:0]);
        atss_pkg::S_FLAG: begin
          for (int i = 0; i < 3; i++) begin
            if (bigv[i]) begin
              seen[i] <= 1'b1;
              if (v[i] > 0) begin
                psum[i] <= (padd[i] > PMAX) ? SW'(PMAX) : SW'(padd[i]);
                lpos[i] <= 1'b1;
              end else begin
                nsum[i] <= (nadd[i] < NMIN) ? SW'(NMIN) : SW'(nadd[i]);
                lpos[i] <= 1'b0;
              end
            end
          end
          if (bigv != 3'b000) qc <= QLOAD;
        end
        atss_pkg::S_SWG: begin
          // A swing is reported once the quiet count has run out.
          if (fire) begin
            for (int i = 0; i < 3; i++) begin
              psum[i] <= '0;
              nsum[i] <= '0;
            end
            lpos <= '0;
            seen <= '0;
          end else if (qc != '0) begin
            qc <= qc - 1'b1;
          end
          gbits <= {1'b0, swing_w, nbits};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == atss_pkg::S_OUT && (!ov || results.ready)) begin
      o_roll <= roll_r;
      o_pitch <= pitch_r;
      o_bits <= gbits[7:0];
      o_chg <= chg;
    end
  end

`ifndef ASSERT_OFF
  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    (roll_r <= 16'sd23040) && (roll_r >= -16'sd23040))
    else $error("roll angle out of range");
  a_quiet_bound: assert property (@(posedge clk) disable iff (rst) qc <= QLOAD)
    else $error("quiet count above load value");
  a_swing_clears: assert property (@(posedge clk) disable iff (rst)
    (state == atss_pkg::S_SWG && swing_w != 3'd0) |=> (seen == 3'b000))
    else $error("swing did not clear accumulated sums");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == atss_pkg::S_OUT && (!ov || results.ready)) |=> (ov && state == atss_pkg::S_IDLE))
    else $error("result not loaded into output register");
`endif

endmodule
`default_nettype wire

>>> dv/tb_accel_tilt_shake_swing_classifier_top.sv
`timescale 1ns / 100ps
module tb_accel_tilt_shake_swing_classifier_top;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic front;
    logic back;
    logic left;
    logic right;
    logic shake;
    logic [2:0] swing;
    logic changed;
  } gesture_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_SILENT} row_kind_t;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] z;
    row_kind_t kind;
    gesture_t res;
  } sample_row_t;

  localparam logic [2:0] IDX_UNUSED_A = 3'd6;
  localparam logic [2:0] IDX_UNUSED_B = 3'd7;
  localparam int DRAIN_CYCLES = 300;
  localparam longint ATAN_Q16[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                      256, 128, 64, 32, 16, 8, 4, 2};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  atss_sample_if samples();
  atss_result_if results();

  accel_tilt_shake_swing_classifier_top dut (
    .clk(clk), .rst(rst), .samples(samples), .results(results),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state.
  logic [7:0] cal_zero[3];
  logic [7:0] cal_one[3];
  longint last_axes[3];
  bit have_last;
  longint last_roll, last_pitch;
  logic [7:0] flag_bits;
  int quiet_left;
  longint pos_acc[3], neg_acc[3];
  bit last_pos[3], axis_hit[3];

  gesture_t gestures_due[$];
  int errors = 0;
  bit idle_on = 1'b1;
  bit hold_start = 1'b0;
  logic [7:0] prev_raw[3];

  function automatic longint calibrate_axis(logic [7:0] raw, logic [7:0] z, logic [7:0] o);
    longint num, den, q;
    num = longint'(raw) - longint'(z);
    den = longint'(o) - longint'(z);
    if (den == 0) return num > 0 ? 32767 : (num < 0 ? -32768 : 0);
    q = (num * atss_pkg::ONE) / den;
    return q > 32767 ? 32767 : (q < -32768 ? -32768 : q);
  endfunction

  function automatic longint cordic_angle(longint a, longint b);
    longint ang, da, db;
    ang = 0;
    for (int i = 0; i < 16; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a += da; b -= db; ang += ATAN_Q16[i];
      end else begin
        a -= da; b += db; ang -= ATAN_Q16[i];
      end
    end
    return ang;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bv;
    res = 0;
    bv = 64'd1 << 62;
    while (bv > v) bv >>= 2;
    while (bv != 0) begin
      if (v >= res + bv) begin
        v -= res + bv;
        res = (res >> 1) + bv;
      end else begin
        res >>= 1;
      end
      bv >>= 2;
    end
    return res;
  endfunction

  function automatic longint round_div(longint n, longint d);
    return n >= 0 ? (n + d / 2) / d : -((-n + d / 2) / d);
  endfunction

  function automatic longint clamp_to(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  task automatic reset_predictor();
    for (int k = 0; k < 3; k++) begin
      cal_zero[k] = 8'd128;
      cal_one[k] = 8'd154;
      last_axes[k] = 0;
      pos_acc[k] = 0;
      neg_acc[k] = 0;
      last_pos[k] = 0;
      axis_hit[k] = 0;
    end
    have_last = 0;
    last_roll = 0;
    last_pitch = 0;
    flag_bits = 0;
    quiet_left = 0;
  endtask

  function automatic bit classify_sample(logic [7:0] rx, logic [7:0] ry, logic [7:0] rz,
                                         output gesture_t r);
    longint v[3], val[3], ab[3];
    longint roll, pitch, a, b, base, ang, mag2, m;
    longint unsigned rr;
    longint pmax, nmin;
    logic [7:0] bits, old;
    logic [2:0] swing;
    bit big;
    pmax = (longint'(1) <<< (atss_pkg::SUM_WIDTH - 1)) - 1;
    nmin = -(longint'(1) <<< (atss_pkg::SUM_WIDTH - 1));
    bits = 0;
    old = flag_bits;
    swing = 0;
    big = 0;
    r = '0;
    v[0] = calibrate_axis(rx, cal_zero[0], cal_one[0]);
    v[1] = calibrate_axis(ry, cal_zero[1], cal_one[1]);
    v[2] = calibrate_axis(rz, cal_zero[2], cal_one[2]);
    if (have_last && v[0] == last_axes[0] && v[1] == last_axes[1] && v[2] == last_axes[2])
      return 0;
    have_last = 1;
    for (int k = 0; k < 3; k++) last_axes[k] = v[k];

    if (v[2] != 0) begin
      a = v[2] * 16384;
      b = v[0] * 16384;
      base = 0;
      if (v[2] < 0) begin
        base = v[0] > 0 ? longint'(atss_pkg::CORDIC_PI) : -longint'(atss_pkg::CORDIC_PI);
        a = -a;
        b = -b;
      end
      ang = base + cordic_angle(a, b);
      roll = clamp_to(round_div(ang * 75264, 655360), 23040);
      rr = int_sqrt(longint'(v[0] * v[0] + v[2] * v[2]) << 28);
      ang = cordic_angle(longint'(rr), v[1] * 16384);
      pitch = clamp_to(-round_div(ang * 59, 512), 11520);
    end else begin
      roll = last_roll;
      pitch = last_pitch;
    end
    last_roll = roll;
    last_pitch = pitch;

    if (pitch < -3840) bits[0] = 1;
    else if (pitch > 3840) bits[1] = 1;
    if (old[0] && pitch < -2560) bits[0] = 1;
    if (old[1] && pitch > 2560) bits[1] = 1;
    if (roll > 5760) bits[3] = 1;
    else if (roll < -5760) bits[2] = 1;
    if (old[3] && roll > 4480) bits[3] = 1;
    if (old[2] && roll < -4480) bits[2] = 1;
    mag2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    if (mag2 * 100 > longint'(484) * atss_pkg::ONE * atss_pkg::ONE) bits[4] = 1;

    for (int k = 0; k < 3; k++) begin
      m = v[k] < 0 ? -v[k] : v[k];
      if (m > 2 * atss_pkg::ONE) begin
        big = 1;
        axis_hit[k] = 1;
        if (v[k] > 0) begin
          pos_acc[k] = pos_acc[k] + v[k] > pmax ? pmax : pos_acc[k] + v[k];
          last_pos[k] = 1;
        end else begin
          neg_acc[k] = neg_acc[k] + v[k] < nmin ? nmin : neg_acc[k] + v[k];
          last_pos[k] = 0;
        end
      end
    end
    if (big) quiet_left = atss_pkg::QUIET_ITEMS;

    if (quiet_left == 0 && (axis_hit[0] || axis_hit[1] || axis_hit[2])) begin
      for (int k = 0; k < 3; k++) begin
        val[k] = axis_hit[k] ? (last_pos[k] ? pos_acc[k] : neg_acc[k]) : 0;
        ab[k] = val[k] < 0 ? -val[k] : val[k];
        pos_acc[k] = 0;
        neg_acc[k] = 0;
        last_pos[k] = 0;
        axis_hit[k] = 0;
      end
      // Sideways motion masks some of the forward axis; a pull back is favored.
      if (ab[0] > 20 * atss_pkg::ONE) ab[1] -= 80 * atss_pkg::ONE;
      else if (ab[0] > 10 * atss_pkg::ONE) ab[1] -= 40 * atss_pkg::ONE;
      else if (ab[0] > 5 * atss_pkg::ONE) ab[1] -= 20 * atss_pkg::ONE;
      if (val[1] < -4 * atss_pkg::ONE) ab[1] += 60 * atss_pkg::ONE;
      else if (val[1] < -3 * atss_pkg::ONE) ab[1] += 40 * atss_pkg::ONE;
      else if (val[1] < -2 * atss_pkg::ONE) ab[1] += 20 * atss_pkg::ONE;
      else if (val[1] < -1 * atss_pkg::ONE) ab[1] += 10 * atss_pkg::ONE;
      if (ab[0] > ab[1] && ab[0] > ab[2]) swing = val[0] > 0 ? 3'd1 : 3'd2;
      else if (ab[1] > ab[0] && ab[1] > ab[2]) swing = val[1] > 0 ? 3'd3 : 3'd4;
    end else if (quiet_left > 0) begin
      quiet_left--;
    end
    bits[7:5] = swing;
    flag_bits = bits;

    r.roll = roll[15:0];
    r.pitch = pitch[14:0];
    r.front = bits[0];
    r.back = bits[1];
    r.left = bits[2];
    r.right = bits[3];
    r.shake = bits[4];
    r.swing = swing;
    r.changed = bits != old;
    return 1;
  endfunction

  task automatic field_check(string name, longint e, longint a);
    if (e != a) begin
      errors++;
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, e, a);
    end
  endtask

  task automatic compare_gesture(gesture_t e, gesture_t a);
    field_check("roll_angle", e.roll, a.roll);
    field_check("pitch_angle", e.pitch, a.pitch);
    field_check("tilt_front", e.front, a.front);
    field_check("tilt_back", e.back, a.back);
    field_check("tilt_left", e.left, a.left);
    field_check("tilt_right", e.right, a.right);
    field_check("shake", e.shake, a.shake);
    field_check("swing", e.swing, a.swing);
    field_check("gesture_changed", e.changed, a.changed);
  endtask

  // Result receiver: random stalls, plus one long hold-off on request.
  int stall_left = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_start) begin
      hold_start = 0;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      results.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      results.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 11);
      results.ready <= 1'b0;
    end else begin
      results.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    gesture_t got;
    if (!rst && results.valid && results.ready) begin
      got.roll = results.roll_angle;
      got.pitch = results.pitch_angle;
      got.front = results.tilt_front;
      got.back = results.tilt_back;
      got.left = results.tilt_left;
      got.right = results.tilt_right;
      got.shake = results.shake;
      got.swing = results.swing;
      got.changed = results.gesture_changed;
      if (gestures_due.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat: roll %0d pitch %0d", $time, got.roll, got.pitch);
      end else begin
        compare_gesture(gestures_due.pop_front(), got);
      end
    end
  end

  // Offers one sample beat, starting and ending at a falling edge.
  task automatic send_sample(logic [7:0] x, logic [7:0] y, logic [7:0] z,
                             row_kind_t kind, gesture_t typed);
    gesture_t pred;
    bit has;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      samples.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    samples.valid <= 1'b1;
    samples.raw_x <= x;
    samples.raw_y <= y;
    samples.raw_z <= z;
    forever begin
      @(posedge clk);
      if (samples.ready) break;
    end
    has = classify_sample(x, y, z, pred);
    if (kind == ROW_SILENT && has) begin
      errors++;
      $display("%0t sample %0d/%0d/%0d: expected no result, predictor gives one",
               $time, x, y, z);
    end
    if (kind == ROW_TYPED) begin
      if (!has) begin
        errors++;
        $display("%0t sample %0d/%0d/%0d: expected a result, predictor gives none",
                 $time, x, y, z);
      end else begin
        compare_gesture(typed, pred);
      end
      gestures_due.push_back(typed);
    end else if (has) begin
      gestures_due.push_back(pred);
    end
    prev_raw[0] = x;
    prev_raw[1] = y;
    prev_raw[2] = z;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx <= atss_pkg::R_ONE_G_Z) begin
      if (idx >= atss_pkg::R_ONE_G_X) cal_one[idx - atss_pkg::R_ONE_G_X] = val;
      else cal_zero[idx] = val;
    end
    @(negedge clk);
  endtask

  task automatic set_calibration(logic [7:0] zx, logic [7:0] zy, logic [7:0] zz,
                                 logic [7:0] ox, logic [7:0] oy, logic [7:0] oz);
    samples.valid <= 1'b0;
    while (gestures_due.size() != 0) @(negedge clk);
    // An unchanged sample may still be in flight without any result.
    repeat (200) @(negedge clk);
    write_reg(atss_pkg::R_ZERO_X, zx);
    write_reg(atss_pkg::R_ZERO_Y, zy);
    write_reg(atss_pkg::R_ZERO_Z, zz);
    write_reg(atss_pkg::R_ONE_G_X, ox);
    write_reg(atss_pkg::R_ONE_G_Y, oy);
    write_reg(atss_pkg::R_ONE_G_Z, oz);
    write_reg(IDX_UNUSED_A, 8'($urandom));
    write_reg(IDX_UNUSED_B, 8'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] axis_raw(int k, bit big);
    int span, d, r;
    span = int'(cal_one[k]) - int'(cal_zero[k]);
    if (span < 0) span = -span;
    if (span == 0) span = 26;
    if (big) begin
      d = 2 * span + 1 + int'($urandom_range(0, 3 * span + 4));
      if ($urandom_range(0, 1)) d = -d;
    end else begin
      d = int'($urandom_range(0, 2 * span + 4)) - (span + 2);
    end
    r = int'(cal_zero[k]) + d;
    return r < 0 ? 8'd0 : (r > 255 ? 8'd255 : 8'(r));
  endfunction

  // Mostly swing gestures (a few hard samples, then a quiet tail), plus
  // repeated samples and raw noise.
  task automatic random_phase(int count);
    int sent, n_big, n_quiet, pick;
    logic [7:0] s[3];
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        n_big = $urandom_range(1, 4);
        n_quiet = $urandom_range(8, 14);
        for (int i = 0; i < n_big + n_quiet; i++) begin
          for (int k = 0; k < 3; k++)
            s[k] = axis_raw(k, i < n_big && $urandom_range(0, 2) != 0);
          send_sample(s[0], s[1], s[2], ROW_PREDICT, '0);
        end
        sent += n_big + n_quiet;
      end else if (pick < 85) begin
        send_sample(prev_raw[0], prev_raw[1], prev_raw[2], ROW_PREDICT, '0);
        sent++;
      end else begin
        send_sample(8'($urandom), 8'($urandom), 8'($urandom), ROW_PREDICT, '0);
        sent++;
      end
    end
  endtask

  function automatic sample_row_t mk_row(logic [7:0] x, logic [7:0] y, logic [7:0] z,
                                         row_kind_t kind, gesture_t res);
    sample_row_t row;
    row.x = x;
    row.y = y;
    row.z = z;
    row.kind = kind;
    row.res = res;
    return row;
  endfunction

  sample_row_t dir_tab[22];

  initial begin
    gesture_t level, shaken;
    int waited;
    samples.valid = 1'b0;
    samples.raw_x = '0;
    samples.raw_y = '0;
    samples.raw_z = '0;
    results.ready = 1'b0;
    prev_raw = '{8'd128, 8'd128, 8'd128};
    reset_predictor();

    level = '0;
    shaken = '0;
    shaken.shake = 1'b1;
    shaken.changed = 1'b1;
    dir_tab[0] = mk_row(8'd128, 8'd128, 8'd128, ROW_TYPED, level);
    dir_tab[1] = mk_row(8'd128, 8'd128, 8'd128, ROW_SILENT, '0);
    dir_tab[2] = mk_row(8'd255, 8'd128, 8'd128, ROW_TYPED, shaken);
    dir_tab[3] = mk_row(8'd0, 8'd0, 8'd0, ROW_PREDICT, '0);
    dir_tab[4] = mk_row(8'd255, 8'd255, 8'd255, ROW_PREDICT, '0);
    dir_tab[5] = mk_row(8'd128, 8'd128, 8'd154, ROW_PREDICT, '0);
    dir_tab[6] = mk_row(8'd128, 8'd128, 8'd102, ROW_PREDICT, '0);
    dir_tab[7] = mk_row(8'd154, 8'd128, 8'd102, ROW_PREDICT, '0);
    dir_tab[8] = mk_row(8'd102, 8'd128, 8'd102, ROW_PREDICT, '0);
    dir_tab[9] = mk_row(8'd180, 8'd128, 8'd154, ROW_PREDICT, '0);
    dir_tab[10] = mk_row(8'd165, 8'd128, 8'd154, ROW_PREDICT, '0);
    dir_tab[11] = mk_row(8'd76, 8'd128, 8'd154, ROW_PREDICT, '0);
    dir_tab[12] = mk_row(8'd128, 8'd180, 8'd154, ROW_PREDICT, '0);
    dir_tab[13] = mk_row(8'd128, 8'd160, 8'd154, ROW_PREDICT, '0);
    dir_tab[14] = mk_row(8'd128, 8'd76, 8'd154, ROW_PREDICT, '0);
    dir_tab[15] = mk_row(8'd0, 8'd255, 8'd128, ROW_PREDICT, '0);
    dir_tab[16] = mk_row(8'd255, 8'd0, 8'd200, ROW_PREDICT, '0);
    dir_tab[17] = mk_row(8'd129, 8'd128, 8'd154, ROW_PREDICT, '0);
    dir_tab[18] = mk_row(8'd130, 8'd128, 8'd154, ROW_PREDICT, '0);
    dir_tab[19] = mk_row(8'd131, 8'd127, 8'd154, ROW_PREDICT, '0);
    dir_tab[20] = mk_row(8'd128, 8'd128, 8'd155, ROW_PREDICT, '0);
    dir_tab[21] = mk_row(8'd0, 8'd255, 8'd0, ROW_PREDICT, '0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i])
      send_sample(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].kind, dir_tab[i].res);
    // Quiet tail so the hard samples above end in a swing.
    for (int i = 0; i < 12; i++)
      send_sample(8'(128 + i % 3), 8'(127 + i % 2), 8'(150 + i), ROW_PREDICT, '0);

    random_phase(120);
    hold_start = 1'b1;
    random_phase(130);

    // Zero span on two axes and an inverted span on the third.
    set_calibration(8'd100, 8'd200, 8'd255, 8'd100, 8'd60, 8'd255);
    random_phase(180);
    set_calibration(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    random_phase(140);
    set_calibration(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    random_phase(140);
    set_calibration(8'($urandom_range(100, 156)), 8'($urandom_range(100, 156)),
                    8'($urandom_range(100, 156)), 8'($urandom_range(160, 190)),
                    8'($urandom_range(60, 96)), 8'($urandom_range(160, 190)));
    random_phase(180);
    set_calibration(8'd128, 8'd128, 8'd128, 8'd154, 8'd154, 8'd154);
    idle_on = 1'b0;
    random_phase(150);

    samples.valid <= 1'b0;
    waited = 0;
    while (gestures_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (gestures_due.size() != 0) begin
      errors += gestures_due.size();
      $display("%0t %0d expected results never arrived", $time, gestures_due.size());
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
